### rtl/core/assert_macros.svh
// Assertion macros used by the top level of the list engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/ials_pkg.sv
// Types and constants shared by the list engine and its storage cells.
package ials_pkg;

   localparam int VALUE_W = 32;
   localparam int OP_W = 3;
   localparam int INDEX_W = 4;
   localparam int STATUS_W = 2;
   localparam int MATCH_W = 5;
   localparam int COUNT_W = 5;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OP_W-1:0] OP_POP = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

   localparam logic [MATCH_W-1:0] MATCH_NONE = 5'h1F;

   typedef enum logic [1:0] {
      SHIFT_HOLD = 2'd0,
      SHIFT_GROW = 2'd1,
      SHIFT_SHRINK = 2'd2
   } shift_mode_type;

   typedef struct packed {
      shift_mode_type mode;
      logic [VALUE_W-1:0] data;
      logic [VALUE_W-1:0] key;
      logic probe;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      STATE_IDLE = 2'b01,
      STATE_SCAN = 2'b10
   } state_type;

endpackage

### rtl/core/ials_cell.sv
// One storage cell of the list: holds one entry, shifts with its neighbors and compares a key.
module ials_cell #(
   parameter int IW = 4,
   parameter int POS = 0
) (
   input logic clock,
   input ials_pkg::cell_cmd_type cmd,
   input logic [IW-1:0] bound,
   input logic [ials_pkg::VALUE_W-1:0] prev_value,
   input logic [ials_pkg::VALUE_W-1:0] next_value,
   output logic [ials_pkg::VALUE_W-1:0] value,
   output logic hit
);

   localparam logic [IW-1:0] POS_IDX = IW'(POS);

   logic [ials_pkg::VALUE_W-1:0] value_ff;
   logic [ials_pkg::VALUE_W-1:0] value_in;
   logic hit_ff;
   logic hit_in;

   always_comb begin
      value_in = value_ff;
      case (cmd.mode)
         ials_pkg::SHIFT_GROW: begin
            if (POS_IDX == bound) begin
               value_in = cmd.data;
            end else if (POS_IDX > bound) begin
               value_in = prev_value;
            end
         end
         ials_pkg::SHIFT_SHRINK: begin
            if (POS_IDX >= bound) begin
               value_in = next_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
      hit_in = cmd.probe ? (value_ff == cmd.key) : hit_ff;
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      hit_ff <= hit_in;
   end

   assign value = value_ff;
   assign hit = hit_ff;

endmodule

### rtl/core/indexed_array_list_engine.sv
// Top level of the indexed array list engine: control, cell chain and result register.
//
// Each request word carries one operation on an ordered list of up to DEPTH signed
// 32-bit values: push, pop, insert at an index, delete at an index, or search for a key.
// Each request produces exactly one response word with a status, the match index of a
// search, the entry count after the operation and the last entry (zero when empty).
// The list lives in a chain of cells with the last entry in cell zero, so push, pop,
// insert and delete move every affected cell one place at once. Push, pop, insert,
// delete and unused codes give their response in the cycle after the request is taken.
// A search first latches a compare flag in every cell, then walks the flags from the
// oldest entry, one cell per cycle; a search of an empty list answers in the cycle
// after the request is taken.
// One request is in flight at a time. A new request is taken while the previous
// response still waits, as long as the response register frees up in that cycle.
// When the receiver stalls, the response word holds and requests wait behind it.
// Reset empties the list and drops any pending response; entry contents are not cleared.
`include "assert_macros.svh"

module indexed_array_list_engine #(
   parameter int DEPTH = 16
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // op [2:0], index [6:3], value [38:7], zero fill [39]
   input logic [ials_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // status [1:0], match_index [6:2], count [11:7], top_value [43:12], zero fill [47:44]
   output logic [ials_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > ials_pkg::INDEX_W) ? CW : ials_pkg::INDEX_W;

   ials_pkg::state_type state_ff;
   ials_pkg::state_type state_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [IW-1:0] scan_ff;
   logic [IW-1:0] scan_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic [ials_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic [ials_pkg::RSP_TDATA_W-1:0] rsp_data_in;

   ials_pkg::cell_cmd_type cmd;
   logic [IW-1:0] bound;
   logic [ials_pkg::VALUE_W-1:0] value_w [DEPTH];
   logic [DEPTH-1:0] hit_w;

   logic req_fire;
   logic out_free;
   logic [ials_pkg::OP_W-1:0] req_op;
   logic [ials_pkg::INDEX_W-1:0] req_index;
   logic [ials_pkg::VALUE_W-1:0] req_value;
   logic [XW-1:0] idx_x;
   logic [XW-1:0] cnt_x;
   logic list_full;
   logic list_empty;
   logic idx_ok;
   logic [ials_pkg::STATUS_W-1:0] status;
   logic [ials_pkg::VALUE_W-1:0] new_top;
   logic hit_now;
   logic [CW-1:0] match_pos;

   assign req_op = req_tdata[2:0];
   assign req_index = req_tdata[6:3];
   assign req_value = req_tdata[38:7];

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ials_pkg::STATE_IDLE) && out_free;
   assign req_fire = req_tvalid && req_tready;

   assign idx_x = XW'(req_index);
   assign cnt_x = XW'(count_ff);
   assign list_full = count_ff >= CW'(DEPTH);
   assign list_empty = count_ff == '0;
   assign idx_ok = idx_x < cnt_x;
   assign hit_now = hit_w[scan_ff];
   assign match_pos = count_ff - CW'(1) - CW'(scan_ff);

   always_comb begin
      cmd.mode = ials_pkg::SHIFT_HOLD;
      cmd.data = req_value;
      cmd.key = req_value;
      cmd.probe = 1'b0;
      bound = '0;
      count_in = count_ff;
      status = ials_pkg::STAT_OK;
      new_top = value_w[0];
      state_in = state_ff;
      scan_in = scan_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;

      case (req_op)
         ials_pkg::OP_PUSH: begin
            if (list_full) begin
               status = ials_pkg::STAT_FULL;
            end else begin
               cmd.mode = ials_pkg::SHIFT_GROW;
               count_in = count_ff + CW'(1);
               new_top = req_value;
            end
         end
         ials_pkg::OP_POP: begin
            if (list_empty) begin
               status = ials_pkg::STAT_EMPTY;
            end else begin
               cmd.mode = ials_pkg::SHIFT_SHRINK;
               count_in = count_ff - CW'(1);
               new_top = value_w[1];
            end
         end
         ials_pkg::OP_INSERT: begin
            if (!idx_ok) begin
               status = ials_pkg::STAT_BAD_INDEX;
            end else if (list_full) begin
               status = ials_pkg::STAT_FULL;
            end else begin
               cmd.mode = ials_pkg::SHIFT_GROW;
               bound = IW'(cnt_x - idx_x);
               count_in = count_ff + CW'(1);
            end
         end
         ials_pkg::OP_DELETE: begin
            if (!idx_ok) begin
               status = ials_pkg::STAT_BAD_INDEX;
            end else begin
               cmd.mode = ials_pkg::SHIFT_SHRINK;
               bound = IW'(cnt_x - idx_x - XW'(1));
               count_in = count_ff - CW'(1);
               if (bound == '0) begin
                  new_top = value_w[1];
               end
            end
         end
         ials_pkg::OP_SEARCH: begin
            cmd.probe = 1'b1;
         end
         default: begin
            status = ials_pkg::STAT_OK;
         end
      endcase

      if (!req_fire) begin
         cmd.mode = ials_pkg::SHIFT_HOLD;
         cmd.probe = 1'b0;
         count_in = count_ff;
      end

      if (req_fire) begin
         if (req_op == ials_pkg::OP_SEARCH && !list_empty) begin
            state_in = ials_pkg::STATE_SCAN;
            scan_in = IW'(count_ff - CW'(1));
         end else begin
            rsp_valid_in = 1'b1;
            rsp_data_in = {
               4'b0,
               (count_in == '0) ? {ials_pkg::VALUE_W{1'b0}} : new_top,
               ials_pkg::COUNT_W'(count_in),
               ials_pkg::MATCH_NONE,
               status
            };
         end
      end else if (state_ff == ials_pkg::STATE_SCAN) begin
         if (hit_now || scan_ff == '0) begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {
                  4'b0,
                  value_w[0],
                  ials_pkg::COUNT_W'(count_ff),
                  hit_now ? ials_pkg::MATCH_W'(match_pos) : ials_pkg::MATCH_NONE,
                  ials_pkg::STAT_OK
               };
               state_in = ials_pkg::STATE_IDLE;
            end
         end else begin
            scan_in = scan_ff - IW'(1);
         end
      end
   end

   for (genvar p = 0; p < DEPTH; p++) begin : g_cell
      logic [ials_pkg::VALUE_W-1:0] prev_value;
      logic [ials_pkg::VALUE_W-1:0] next_value;

      if (p == 0) begin : g_first
         assign prev_value = req_value;
      end else begin : g_inner_prev
         assign prev_value = value_w[p-1];
      end

      if (p == DEPTH - 1) begin : g_last
         assign next_value = value_w[p];
      end else begin : g_inner_next
         assign next_value = value_w[p+1];
      end

      ials_cell #(
         .IW(IW),
         .POS(p)
      ) u_cell (
         .clock(clock),
         .cmd(cmd),
         .bound(bound),
         .prev_value(prev_value),
         .next_value(next_value),
         .value(value_w[p]),
         .hit(hit_w[p])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ials_pkg::STATE_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CW'(DEPTH), "count above depth")
   `ASSERT_IMPLY(a_scan_nonempty, clock, reset, state_ff == ials_pkg::STATE_SCAN, count_ff != '0, "scan of empty list")
   `ASSERT_NEXT(a_search_keeps_count, clock, reset, req_fire && req_op == ials_pkg::OP_SEARCH, $stable(count_ff), "search changed count")

endmodule
